[src/gbfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared sizes, codes and interface structs of the graph traversal engine.
// ----------------------------------------------------------------------------
package gbfs_pkg;

    // Graph sizes
    localparam int MAX_NODES   = 64;
    localparam int MAX_ENTRIES = 512;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int ENTRY_W  = $clog2(MAX_ENTRIES);
    localparam int ENTCNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int QPOS_W   = $clog2(MAX_NODES + 1);
    localparam int COUNT_W  = 7;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_NODES);
    localparam logic [ENTCNT_W-1:0] ENT_LIMIT  = ENTCNT_W'(MAX_ENTRIES - 2);

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_TRAVERSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_A,
        S_ADD_B,
        S_TR_INIT,
        S_POP,
        S_NODE,
        S_HEAD,
        S_SCAN,
        S_FLUSH
    } ctrl_state_t;

    // One result beat
    typedef struct packed {
        node_t   node;
        status_t status;
        logic    last;
    } result_t;

    // Requests to the adjacency store
    typedef struct packed {
        logic   rd_en;       // read head/tail of rd_node
        node_t  rd_node;
        logic   ent_rd_en;   // read neighbor/link of one entry
        entry_t ent_rd_addr;
        logic   app_en;      // append one entry to a node list
        node_t  app_node;
        node_t  app_nb;
        entry_t app_entry;
        entry_t app_tail;    // current tail of app_node (forwarded)
        logic   clear_all;
    } adj_req_t;

    // Registered read data from the adjacency store
    typedef struct packed {
        entry_t head;
        entry_t tail;
        node_t  nb;
        entry_t link;
    } adj_rsp_t;

    // Requests to the pending-node queue
    typedef struct packed {
        logic  clear;
        logic  push;
        node_t push_data;
        logic  pop;
    } queue_req_t;

endpackage

[src/gbfs_adj_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_adj_store
// Neighbor lists: entry pool memories plus per-node head/tail memories.
// ----------------------------------------------------------------------------
module gbfs_adj_store
    import gbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adj_req_t             req,
    output adj_rsp_t             rsp,
    output logic [MAX_NODES-1:0] list_used
);

    // Entry pool and list pointer memories
    node_t  nb_mem   [MAX_ENTRIES];
    entry_t link_mem [MAX_ENTRIES];
    entry_t head_mem [MAX_NODES];
    entry_t tail_mem [MAX_NODES];

    logic [MAX_NODES-1:0] used_reg;
    logic [MAX_NODES-1:0] used_next;

    // List-in-use flags
    always_comb
    begin
        used_next = used_reg;
        if (req.clear_all)
        begin
            used_next = '0;
        end
        else if (req.app_en)
        begin
            used_next[req.app_node] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign list_used = used_reg;

    // Append: new entry, then link it from the old tail or make it the head
    always_ff @(posedge clk)
    begin
        if (req.app_en)
        begin
            nb_mem[req.app_entry]   <= req.app_nb;
            tail_mem[req.app_node]  <= req.app_entry;
            if (used_reg[req.app_node])
            begin
                link_mem[req.app_tail] <= req.app_entry;
            end
            else
            begin
                head_mem[req.app_node] <= req.app_entry;
            end
        end
    end

    // Head/tail and entry read ports
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp.head <= head_mem[req.rd_node];
            rsp.tail <= tail_mem[req.rd_node];
        end
        if (req.ent_rd_en)
        begin
            rsp.nb   <= nb_mem[req.ent_rd_addr];
            rsp.link <= link_mem[req.ent_rd_addr];
        end
    end

endmodule

[src/gbfs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_queue
// FIFO of pending nodes for the traversal, held in a small memory.
// ----------------------------------------------------------------------------
module gbfs_queue
    import gbfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  queue_req_t req,
    output logic       empty,
    output logic       full,
    output node_t      pop_data
);

    node_t q_mem [MAX_NODES];

    logic [QPOS_W-1:0] rd_pos_reg;
    logic [QPOS_W-1:0] rd_pos_next;
    logic [QPOS_W-1:0] wr_pos_reg;
    logic [QPOS_W-1:0] wr_pos_next;
    logic [QPOS_W-1:0] wr_addr;

    assign empty = (rd_pos_reg == wr_pos_reg);
    assign full  = (wr_pos_reg == QPOS_W'(MAX_NODES));

    // A clear restarts both pointers; a push in the same beat lands at slot zero
    assign wr_addr = req.clear ? '0 : wr_pos_reg;

    always_comb
    begin
        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        if (req.clear)
        begin
            rd_pos_next = '0;
            wr_pos_next = req.push ? QPOS_W'(1) : '0;
        end
        else
        begin
            if (req.push)
            begin
                wr_pos_next = wr_pos_reg + QPOS_W'(1);
            end
            if (req.pop)
            begin
                rd_pos_next = rd_pos_reg + QPOS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos_reg <= '0;
            wr_pos_reg <= '0;
        end
        else
        begin
            rd_pos_reg <= rd_pos_next;
            wr_pos_reg <= wr_pos_next;
        end
    end

    // Queue memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            q_mem[wr_addr[NODE_W-1:0]] <= req.push_data;
        end
        if (req.pop)
        begin
            pop_data <= q_mem[rd_pos_reg[NODE_W-1:0]];
        end
    end

endmodule

[src/gbfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Sequencer for edge inserts, clears and breadth-first traversal.
// ----------------------------------------------------------------------------
module gbfs_ctrl
    import gbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  op_t                  op,
    input  node_t                edge_from,
    input  node_t                edge_to,
    input  node_t                start_node,
    input  logic [COUNT_W-1:0]   eff_count,
    input  logic                 out_free,
    output logic                 res_valid,
    output result_t              res,
    output adj_req_t             adj_req,
    input  adj_rsp_t             adj_rsp,
    input  logic [MAX_NODES-1:0] list_used,
    output queue_req_t           q_req,
    input  logic                 q_empty,
    input  logic                 q_full,
    input  node_t                q_data
);

    ctrl_state_t state_reg, state_next;

    node_t                from_reg, from_next;
    node_t                to_reg, to_next;
    node_t                start_reg, start_next;
    logic [ENTCNT_W-1:0]  entries_reg, entries_next;
    node_t                hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;
    entry_t               e_reg, e_next;
    entry_t               tail_reg, tail_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;

    logic                accept;
    logic                add_bad;
    logic                add_full;
    logic                trav_bad;
    logic                emit_ok;
    logic [ENTCNT_W-1:0] entries_plus1;

    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    // Item checks
    assign add_bad  = ({1'b0, edge_from} >= eff_count) || ({1'b0, edge_to} >= eff_count);
    assign add_full = (entries_reg > ENT_LIMIT);
    assign trav_bad = ({1'b0, start_node} >= eff_count);
    assign entries_plus1 = entries_reg + ENTCNT_W'(1);

    // Result beat may leave when no earlier node is held or the slot frees up
    assign emit_ok = !hold_valid_reg || out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ADD_EDGE: state_next = (add_bad || add_full) ? S_IDLE : S_ADD_RD;
                        OP_TRAVERSE: state_next = trav_bad ? S_IDLE : S_TR_INIT;
                        OP_CLEAR:    state_next = S_IDLE;
                        OP_NOP:      state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:  state_next = S_ADD_A;
            S_ADD_A:   state_next = S_ADD_B;
            S_ADD_B:   state_next = S_IDLE;
            S_TR_INIT: state_next = S_POP;
            S_POP:     state_next = q_empty ? S_FLUSH : S_NODE;
            S_NODE:
            begin
                if (emit_ok)
                begin
                    state_next = list_used[q_data] ? S_HEAD : S_POP;
                end
            end
            S_HEAD:    state_next = S_SCAN;
            S_SCAN:    state_next = (e_reg == tail_reg) ? S_POP : S_SCAN;
            S_FLUSH:   state_next = out_free ? S_IDLE : S_FLUSH;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        from_next       = from_reg;
        to_next         = to_reg;
        start_next      = start_reg;
        entries_next    = entries_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        e_next          = e_reg;
        tail_next       = tail_reg;
        visited_next    = visited_reg;

        res_valid  = 1'b0;
        res.node   = '0;
        res.status = STAT_OK;
        res.last   = 1'b0;

        adj_req = '0;
        q_req   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    from_next  = edge_from;
                    to_next    = edge_to;
                    start_next = start_node;
                    unique case (op)
                        OP_ADD_EDGE:
                        begin
                            if (add_bad)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_RANGE;
                                res.last   = 1'b1;
                            end
                            else if (add_full)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_FULL;
                                res.last   = 1'b1;
                            end
                        end
                        OP_TRAVERSE:
                        begin
                            if (trav_bad)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_RANGE;
                                res.last   = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            adj_req.clear_all = 1'b1;
                            entries_next      = '0;
                        end
                        OP_NOP:
                        begin
                            entries_next = entries_reg;
                        end
                    endcase
                end
            end

            // Fetch tail of the first endpoint
            S_ADD_RD:
            begin
                adj_req.rd_en   = 1'b1;
                adj_req.rd_node = from_reg;
            end

            // Append second endpoint to the first list, fetch the second tail
            S_ADD_A:
            begin
                adj_req.app_en    = 1'b1;
                adj_req.app_node  = from_reg;
                adj_req.app_nb    = to_reg;
                adj_req.app_entry = entries_reg[ENTRY_W-1:0];
                adj_req.app_tail  = adj_rsp.tail;
                adj_req.rd_en     = 1'b1;
                adj_req.rd_node   = to_reg;
            end

            // Append first endpoint to the second list; self loop forwards tail
            S_ADD_B:
            begin
                adj_req.app_en    = 1'b1;
                adj_req.app_node  = to_reg;
                adj_req.app_nb    = from_reg;
                adj_req.app_entry = entries_plus1[ENTRY_W-1:0];
                adj_req.app_tail  = (from_reg == to_reg) ? entries_reg[ENTRY_W-1:0]
                                                         : adj_rsp.tail;
                entries_next      = entries_reg + ENTCNT_W'(2);
                res_valid         = 1'b1;
                res.status        = STAT_OK;
                res.last          = 1'b1;
            end

            // Fresh marks, seed the queue with the start node
            S_TR_INIT:
            begin
                visited_next            = '0;
                visited_next[start_reg] = 1'b1;
                q_req.clear             = 1'b1;
                q_req.push              = 1'b1;
                q_req.push_data         = start_reg;
                hold_valid_next         = 1'b0;
            end

            S_POP:
            begin
                q_req.pop = !q_empty;
            end

            // Release the previously held node, hold the new one
            S_NODE:
            begin
                if (emit_ok)
                begin
                    res_valid       = hold_valid_reg;
                    res.node        = hold_reg;
                    hold_next       = q_data;
                    hold_valid_next = 1'b1;
                    adj_req.rd_en   = 1'b1;
                    adj_req.rd_node = q_data;
                end
            end

            S_HEAD:
            begin
                e_next              = adj_rsp.head;
                tail_next           = adj_rsp.tail;
                adj_req.ent_rd_en   = 1'b1;
                adj_req.ent_rd_addr = adj_rsp.head;
            end

            // One list entry per beat
            S_SCAN:
            begin
                if (!visited_reg[adj_rsp.nb] && !q_full)
                begin
                    visited_next[adj_rsp.nb] = 1'b1;
                    q_req.push               = 1'b1;
                    q_req.push_data          = adj_rsp.nb;
                end
                if (e_reg != tail_reg)
                begin
                    e_next              = adj_rsp.link;
                    adj_req.ent_rd_en   = 1'b1;
                    adj_req.ent_rd_addr = adj_rsp.link;
                end
            end

            // Final node carries the last flag
            S_FLUSH:
            begin
                if (out_free)
                begin
                    res_valid       = 1'b1;
                    res.node        = hold_reg;
                    res.last        = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            entries_reg    <= '0;
            hold_valid_reg <= 1'b0;
            visited_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            entries_reg    <= entries_next;
            hold_valid_reg <= hold_valid_next;
            visited_reg    <= visited_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        from_reg  <= from_next;
        to_reg    <= to_next;
        start_reg <= start_next;
        hold_reg  <= hold_next;
        e_reg     <= e_next;
        tail_reg  <= tail_next;
    end

endmodule

[src/graph_bfs_engine.sv]
`timescale 1ns / 1ps
// Add edge: result after states ADD_RD, ADD_A and ADD_B; range or full errors from idle.
// Traverse: setup in TR_INIT, then POP and NODE per reached node, plus HEAD and a SCAN
//   step per entry when its list is in use (single entry-memory read port); then FLUSH.
// Clear and no-op: no result. One item at a time; result stalls hold the engine.
// Reset: node_count returns to 64, list and visited flags and counters clear at once;
//   entry, pointer and queue memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// graph_bfs_engine
// Undirected adjacency-list graph store with breadth-first traversal.
// ----------------------------------------------------------------------------
module graph_bfs_engine
    import gbfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [NODE_W-1:0]   edge_from,
    input  logic [NODE_W-1:0]   edge_to,
    input  logic [NODE_W-1:0]   start_node,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [NODE_W-1:0]   visited_node,
    output logic [STATUS_W-1:0] status,
    output logic                last,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  node_count
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] eff_count;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_free;

    logic                 res_valid;
    result_t              res;
    adj_req_t             adj_req;
    adj_rsp_t             adj_rsp;
    logic [MAX_NODES-1:0] list_used;
    queue_req_t           q_req;
    logic                 q_empty;
    logic                 q_full;
    node_t                q_data;

    // Node count register, clamped to 1..MAX_NODES when used
    assign cfg_ready  = 1'b1;
    assign count_next = (cfg_valid && cfg_ready) ? node_count : count_reg;

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (count_reg > COUNT_RESET)
        begin
            eff_count = COUNT_RESET;
        end
        else
        begin
            eff_count = count_reg;
        end
    end

    // Output register: a new beat loads when the slot is empty or draining
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign visited_node = out_reg.node;
    assign status       = out_reg.status;
    assign last         = out_reg.last;

    gbfs_adj_store u_adj_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (adj_req),
        .rsp       (adj_rsp),
        .list_used (list_used)
    );

    gbfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (q_req),
        .empty    (q_empty),
        .full     (q_full),
        .pop_data (q_data)
    );

    gbfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op_t'(operation)),
        .edge_from  (edge_from),
        .edge_to    (edge_to),
        .start_node (start_node),
        .eff_count  (eff_count),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .adj_req    (adj_req),
        .adj_rsp    (adj_rsp),
        .list_used  (list_used),
        .q_req      (q_req),
        .q_empty    (q_empty),
        .q_full     (q_full),
        .q_data     (q_data)
    );

endmodule
